[rtl/kaq_pkg.sv]
// Shared types and constants of the keyed action queue.
package kaq_pkg;

    localparam int unsigned ID_W     = 32;
    localparam int unsigned ACTION_W = 8;
    localparam int unsigned OCC_W    = 5;

    localparam logic [ACTION_W-1:0] ACTION_NONE = '0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } kaq_status_t;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_TAKE = 1'b1
    } kaq_kind_t;

    typedef struct packed {
        logic        load_key;
        logic        push_write;
        logic        mem_read;
        logic        read_next;
        logic        idx_inc;
        logic        shift_write;
        logic        dec_count;
        logic        set_status;
        kaq_status_t status_code;
        logic        out_load;
    } kaq_cmd_t;

    typedef struct packed {
        logic is_take;
        logic key_invalid;
        logic full;
        logic idx_end;
        logic match;
        logic shift_end;
    } kaq_sts_t;

endpackage

[rtl/kaq_if.sv]
// Valid/ready channel interfaces for request and response words.
interface kaq_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [kaq_pkg::ID_W-1:0]       id;
    logic [kaq_pkg::ACTION_W-1:0]   action;

    modport source (output valid, output kind, output id, output action, input ready);
    modport sink (input valid, input kind, input id, input action, output ready);
endinterface

interface kaq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [kaq_pkg::OCC_W-1:0]      occupancy;

    modport source (output valid, output status, output occupancy, input ready);
    modport sink (input valid, input status, input occupancy, output ready);
endinterface

[rtl/kaq_dp.sv]
// Datapath: entry memory, key, scan index, count and response registers.
module kaq_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kaq_pkg::kaq_cmd_t              cmd,
    output kaq_pkg::kaq_sts_t              sts,
    input  logic                           in_kind,
    input  logic [kaq_pkg::ID_W-1:0]       in_id,
    input  logic [kaq_pkg::ACTION_W-1:0]   in_action,
    output logic [1:0]                     out_status,
    output logic [kaq_pkg::OCC_W-1:0]      out_occupancy
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [kaq_pkg::ID_W-1:0]     mem_id [CAPACITY];
    logic [kaq_pkg::ACTION_W-1:0] mem_action [CAPACITY];

    logic                           kind_reg;
    logic [kaq_pkg::ID_W-1:0]       id_reg;
    logic [kaq_pkg::ACTION_W-1:0]   action_reg;
    logic [CNT_W-1:0]               idx_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [kaq_pkg::ID_W-1:0]       rd_id_reg;
    logic [kaq_pkg::ACTION_W-1:0]   rd_action_reg;
    kaq_pkg::kaq_status_t           status_reg;
    logic [1:0]                     out_status_reg;
    logic [kaq_pkg::OCC_W-1:0]      out_occ_reg;

    logic [CNT_W:0]                 idx_plus;
    logic [IDX_W-1:0]               rd_addr;
    logic [IDX_W-1:0]               wr_addr;
    logic                           wr_en;
    logic [kaq_pkg::ID_W-1:0]       wr_id;
    logic [kaq_pkg::ACTION_W-1:0]   wr_action;

    assign idx_plus = {1'b0, idx_reg} + 1'b1;
    assign rd_addr  = cmd.read_next ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_en    = cmd.push_write | cmd.shift_write;
    assign wr_addr  = cmd.push_write ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_id     = cmd.push_write ? id_reg : rd_id_reg;
    assign wr_action = cmd.push_write ? action_reg : rd_action_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_write)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        sts.is_take     = (kind_reg == kaq_pkg::KIND_TAKE);
        sts.key_invalid = (id_reg == '0) || (action_reg == kaq_pkg::ACTION_NONE);
        sts.full        = (count_reg >= CNT_W'(CAPACITY));
        sts.idx_end     = (idx_reg >= count_reg);
        sts.match       = (rd_id_reg == id_reg) && (rd_action_reg == action_reg);
        sts.shift_end   = (idx_plus >= {1'b0, count_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr]     <= wr_id;
            mem_action[wr_addr] <= wr_action;
        end
        if (cmd.mem_read)
        begin
            rd_id_reg     <= mem_id[rd_addr];
            rd_action_reg <= mem_action[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            kind_reg   <= in_kind;
            id_reg     <= in_id;
            action_reg <= in_action;
            idx_reg    <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_occ_reg    <= kaq_pkg::OCC_W'(count_reg);
        end
    end

    assign out_status    = out_status_reg;
    assign out_occupancy = out_occ_reg;

endmodule

[rtl/kaq_ctrl.sv]
// Controller state machine that sequences push, scan and compaction.
module kaq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  kaq_pkg::kaq_sts_t     sts,
    output kaq_pkg::kaq_cmd_t     cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_FIN      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status_code = kaq_pkg::ST_OK;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_take)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    state_next     = S_FIN;
                    if (sts.key_invalid)
                    begin
                        cmd.status_code = kaq_pkg::ST_INVALID;
                    end
                    else if (sts.full)
                    begin
                        cmd.status_code = kaq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.status_code = kaq_pkg::ST_OK;
                        cmd.push_write  = 1'b1;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (sts.idx_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = kaq_pkg::ST_NOMATCH;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_end)
                begin
                    cmd.dec_count   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = kaq_pkg::ST_OK;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.mem_read  = 1'b1;
                    cmd.read_next = 1'b1;
                    state_next    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_write = 1'b1;
                cmd.idx_inc     = 1'b1;
                state_next      = S_SHIFT_RD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/keyed_action_queue_unit.sv]
// Top level of the keyed action queue: controller, datapath and checks.
// The queue holds up to CAPACITY (id, action) words in arrival order. A push
// appends at the tail; a take finds the oldest entry equal to the key, removes
// it and moves the younger entries down one slot. Each request word yields one
// response word with a status and the occupancy after the request. A take
// scans the entries one at a time from the oldest and, on a match, copies each
// younger entry down one slot, first reading it and then writing it. A new
// request is taken while the previous response still waits in the output
// register.
module keyed_action_queue_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    kaq_req_if.sink    req,
    kaq_rsp_if.source  rsp
);

    kaq_pkg::kaq_cmd_t cmd;
    kaq_pkg::kaq_sts_t sts;

    kaq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kaq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (req.kind),
        .in_id         (req.id),
        .in_action     (req.action),
        .out_status    (rsp.status),
        .out_occupancy (rsp.occupancy)
    );

    // A push must never write into a full queue or store an invalid key.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> (!sts.full && !sts.key_invalid))
        else $error("push written while full or with invalid key");

    // Compaction never copies from beyond the held entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_write |-> !sts.shift_end)
        else $error("compaction ran past the last held entry");

    // Only a take removes an entry; in the controller, removal follows a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> (sts.is_take && $past(cmd.mem_read || cmd.shift_write
            || cmd.idx_inc == 1'b0)))
        else $error("entry removed outside of a take");

endmodule
